>>> rtl/utf8s_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer package
// Shared constants, the command record passed from the front end to the
// back end, and the byte classification functions.
// ----------------------------------------------------------------------------
package utf8s_pkg;

    localparam int BYTE_W      = 8;
    localparam int MAX_RESULTS = 6;
    localparam int CNT_W       = 3;

    localparam logic [7:0] REP_BYTE0 = 8'hEF;
    localparam logic [7:0] REP_BYTE1 = 8'hBF;
    localparam logic [7:0] REP_BYTE2 = 8'hBD;

    localparam logic [7:0] CONT_MIN    = 8'h80;
    localparam logic [7:0] CONT_MAX    = 8'hBF;
    localparam logic [7:0] LEAD2_MIN   = 8'hC2;
    localparam logic [7:0] LEAD2_MAX   = 8'hDF;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD3_MAX   = 8'hEF;
    localparam logic [7:0] LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] LEAD4_MAX   = 8'hF4;
    localparam logic [7:0] LEAD_E0     = 8'hE0;
    localparam logic [7:0] LEAD_ED     = 8'hED;
    localparam logic [7:0] LEAD_F0     = 8'hF0;
    localparam logic [7:0] LEAD_F4     = 8'hF4;
    localparam logic [7:0] LIMIT_A0    = 8'hA0;
    localparam logic [7:0] LIMIT_90    = 8'h90;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]                   cnt;
        logic                               fin;
    } cmd_t;

    function automatic logic [2:0] lead_length(input logic [7:0] c);
        logic [2:0] n;
        n = LEN_NONE;
        if (c inside {[LEAD2_MIN:LEAD2_MAX]}) begin
            n = LEN_TWO;
        end else if (c inside {[LEAD3_MIN:LEAD3_MAX]}) begin
            n = LEN_THREE;
        end else if (c inside {[LEAD4_MIN:LEAD4_MAX]}) begin
            n = LEN_FOUR;
        end
        return n;
    endfunction

    function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                     input logic [7:0] d);
        logic r;
        r = d inside {[CONT_MIN:CONT_MAX]};
        if (pos == 2'd1) begin
            if (lead == LEAD_E0 && d < LIMIT_A0) r = 1'b0;
            if (lead == LEAD_ED && d >= LIMIT_A0) r = 1'b0;
            if (lead == LEAD_F0 && d < LIMIT_90) r = 1'b0;
            if (lead == LEAD_F4 && d >= LIMIT_90) r = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> rtl/utf8_sanitize_replace_core.sv
// Path: the first output byte of an input transfer passes through the command queue and then the output register.
// Throughput: one input transfer per cycle while the command queue has room.
// Output runs one byte per cycle while m_tready is high, so items making several bytes set the sustained rate.
// Reset: synchronous active-low aresetn clears pending state, queue and output.
// ----------------------------------------------------------------------------
// UTF-8 sanitizer core
// Replaces ill-formed UTF-8 in a byte stream with U+FFFD and passes the
// well-formed text through unchanged.
// ----------------------------------------------------------------------------
module utf8_sanitize_replace_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,   // run_end
    output logic       m_tuser    // stream_end
);

    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_valid;
    utf8s_pkg::cmd_t cmd;
    utf8s_pkg::cmd_t q_head;

    utf8s_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .cmd      (cmd)
    );

    utf8s_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (cmd),
        .pop       (pop),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_head)
    );

    utf8s_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    a_final_makes_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |-> push)
        else $error("Final transfer produced no output command.");

    a_stream_end_is_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("Stream end flagged on a byte that does not end its run.");

    a_no_phantom_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (!q_valid && !m_tvalid) |=> !m_tvalid)
        else $error("Output became valid with an empty queue.");
`endif

endmodule

>>> rtl/utf8s_front.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer front end
// Accepts input bytes, tracks the pending sequence and turns each transfer
// that produces bytes into one command listing those bytes.
// ----------------------------------------------------------------------------
module utf8s_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  logic              q_full,
    output logic              push,
    output utf8s_pkg::cmd_t   cmd
);

    logic [2:0]      exp_len_reg, exp_len_next;
    logic [1:0]      held_cnt_reg, held_cnt_next;
    logic [2:0][7:0] held_reg;

    logic            accept;
    logic            pend;
    logic            ok;
    logic            complete;
    logic [2:0]      lead_n;
    logic            hold_we;
    logic [1:0]      hold_idx;
    logic            prefix;
    logic [2:0][7:0] tail_bytes;
    logic [1:0]      tail_cnt;

    assign s_tready = ~q_full;
    assign accept   = s_tvalid & ~q_full;
    assign pend     = exp_len_reg != utf8s_pkg::LEN_NONE;
    assign ok       = utf8s_pkg::cont_ok(held_reg[0], held_cnt_reg, s_tdata);
    assign complete = ({1'b0, held_cnt_reg} + 3'd1) >= exp_len_reg;
    assign lead_n   = utf8s_pkg::lead_length(s_tdata);

    always_comb begin
        cmd           = '0;
        cmd.fin       = s_tlast;
        exp_len_next  = exp_len_reg;
        held_cnt_next = held_cnt_reg;
        hold_we       = 1'b0;
        hold_idx      = held_cnt_reg;
        prefix        = 1'b0;
        tail_bytes    = '0;
        tail_cnt      = 2'd0;
        if (pend && ok && complete) begin
            case (held_cnt_reg)
                2'd1: begin
                    cmd.bytes[0] = held_reg[0];
                    cmd.bytes[1] = s_tdata;
                    cmd.cnt      = 3'd2;
                end
                2'd2: begin
                    cmd.bytes[0] = held_reg[0];
                    cmd.bytes[1] = held_reg[1];
                    cmd.bytes[2] = s_tdata;
                    cmd.cnt      = 3'd3;
                end
                2'd3: begin
                    cmd.bytes[0] = held_reg[0];
                    cmd.bytes[1] = held_reg[1];
                    cmd.bytes[2] = held_reg[2];
                    cmd.bytes[3] = s_tdata;
                    cmd.cnt      = 3'd4;
                end
                default: begin
                    cmd.bytes[0] = s_tdata;
                    cmd.cnt      = 3'd1;
                end
            endcase
            exp_len_next  = utf8s_pkg::LEN_NONE;
            held_cnt_next = 2'd0;
        end else if (pend && ok) begin
            if (s_tlast) begin
                cmd.bytes[0]  = utf8s_pkg::REP_BYTE0;
                cmd.bytes[1]  = utf8s_pkg::REP_BYTE1;
                cmd.bytes[2]  = utf8s_pkg::REP_BYTE2;
                cmd.cnt       = 3'd3;
                exp_len_next  = utf8s_pkg::LEN_NONE;
                held_cnt_next = 2'd0;
            end else begin
                hold_we       = 1'b1;
                held_cnt_next = held_cnt_reg + 2'd1;
            end
        end else begin
            prefix        = pend;
            exp_len_next  = utf8s_pkg::LEN_NONE;
            held_cnt_next = 2'd0;
            if (!s_tdata[7]) begin
                tail_bytes[0] = s_tdata;
                tail_cnt      = 2'd1;
            end else if (lead_n == utf8s_pkg::LEN_NONE || s_tlast) begin
                tail_bytes[0] = utf8s_pkg::REP_BYTE0;
                tail_bytes[1] = utf8s_pkg::REP_BYTE1;
                tail_bytes[2] = utf8s_pkg::REP_BYTE2;
                tail_cnt      = 2'd3;
            end else begin
                hold_we       = 1'b1;
                hold_idx      = 2'd0;
                exp_len_next  = lead_n;
                held_cnt_next = 2'd1;
            end
            if (prefix) begin
                cmd.bytes[0]   = utf8s_pkg::REP_BYTE0;
                cmd.bytes[1]   = utf8s_pkg::REP_BYTE1;
                cmd.bytes[2]   = utf8s_pkg::REP_BYTE2;
                cmd.bytes[5:3] = tail_bytes;
                cmd.cnt        = 3'd3 + {1'b0, tail_cnt};
            end else begin
                cmd.bytes[2:0] = tail_bytes;
                cmd.cnt        = {1'b0, tail_cnt};
            end
        end
    end

    assign push = accept && (cmd.cnt != 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_len_reg  <= utf8s_pkg::LEN_NONE;
            held_cnt_reg <= 2'd0;
        end else if (accept) begin
            exp_len_reg  <= exp_len_next;
            held_cnt_reg <= held_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && hold_we) begin
            held_reg[hold_idx] <= s_tdata;
        end
    end

endmodule

>>> rtl/utf8s_queue.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer command queue
// A small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module utf8s_queue #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  utf8s_pkg::cmd_t   push_data,
    input  logic              pop,
    output logic              full,
    output logic              valid,
    output utf8s_pkg::cmd_t   head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    utf8s_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0]  level_reg, level_next;

    assign full  = level_reg == LVL_W'(DEPTH);
    assign valid = level_reg != '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   level_next = level_reg + 1'b1;
            2'b01:   level_next = level_reg - 1'b1;
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/utf8s_back.sv
// ----------------------------------------------------------------------------
// UTF-8 sanitizer back end
// Walks through the bytes of the command at the queue head and drives them
// one per transfer through the output register.
// ----------------------------------------------------------------------------
module utf8s_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  utf8s_pkg::cmd_t   q_head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic              m_tuser
);

    logic [2:0] idx_reg, idx_next;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;
    logic       m_tuser_reg;

    logic       load;
    logic       fire;
    logic       last;
    logic [7:0] sel_byte;

    assign load = ~m_tvalid_reg | m_tready;
    assign fire = load & q_valid;
    assign last = (idx_reg + 3'd1) == q_head.cnt;
    assign pop  = fire & last;

    always_comb begin
        case (idx_reg)
            3'd0:    sel_byte = q_head.bytes[0];
            3'd1:    sel_byte = q_head.bytes[1];
            3'd2:    sel_byte = q_head.bytes[2];
            3'd3:    sel_byte = q_head.bytes[3];
            3'd4:    sel_byte = q_head.bytes[4];
            3'd5:    sel_byte = q_head.bytes[5];
            default: sel_byte = q_head.bytes[0];
        endcase
        idx_next = idx_reg;
        if (fire) begin
            idx_next = last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            idx_reg      <= 3'd0;
        end else begin
            idx_reg <= idx_next;
            if (load) begin
                m_tvalid_reg <= q_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= sel_byte;
            m_tlast_reg <= last;
            m_tuser_reg <= last & q_head.fin;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> bench/tb_utf8_sanitize_replace_core.sv
// ----------------------------------------------------------------------------
// Testbench for the UTF-8 sanitizer core
// Drives byte streams through the input channel and checks every output
// transfer against a cycle-free model of the sanitizer. Directed tests cover
// ASCII, stray bytes, complete sequences, second-byte limits and truncation at
// the end of a stream; random traffic mixes well-formed and broken sequences
// with random idling on both channels and one long stretch without idling.
// ----------------------------------------------------------------------------
module tb_utf8_sanitize_replace_core;

    typedef struct {
        logic [7:0] data;
        logic       run_end;
        logic       stream_end;
    } out_beat_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    out_beat_t  sanitized_q[$];
    out_beat_t  step_beats[$];
    logic [2:0] seq_len = utf8s_pkg::LEN_NONE;
    logic [2:0] seq_cnt = 3'd0;
    logic [7:0] seq_bytes[3];
    int         bytes_sent = 0;
    int         mismatches = 0;
    bit         steady     = 1'b0;

    utf8_sanitize_replace_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [2:0] seq_length_of(input logic [7:0] c);
        if (c >= utf8s_pkg::LEAD2_MIN && c <= utf8s_pkg::LEAD2_MAX) return utf8s_pkg::LEN_TWO;
        if (c >= utf8s_pkg::LEAD3_MIN && c <= utf8s_pkg::LEAD3_MAX) return utf8s_pkg::LEN_THREE;
        if (c >= utf8s_pkg::LEAD4_MIN && c <= utf8s_pkg::LEAD4_MAX) return utf8s_pkg::LEN_FOUR;
        return utf8s_pkg::LEN_NONE;
    endfunction

    function automatic bit follows_lead(input logic [7:0] lead, input logic [2:0] pos,
                                        input logic [7:0] d);
        if (d < utf8s_pkg::CONT_MIN || d > utf8s_pkg::CONT_MAX) return 1'b0;
        if (pos == 3'd1) begin
            if (lead == utf8s_pkg::LEAD_E0 && d < utf8s_pkg::LIMIT_A0) return 1'b0;
            if (lead == utf8s_pkg::LEAD_ED && d >= utf8s_pkg::LIMIT_A0) return 1'b0;
            if (lead == utf8s_pkg::LEAD_F0 && d < utf8s_pkg::LIMIT_90) return 1'b0;
            if (lead == utf8s_pkg::LEAD_F4 && d >= utf8s_pkg::LIMIT_90) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        out_beat_t beat;
        beat.data       = b;
        beat.run_end    = 1'b0;
        beat.stream_end = 1'b0;
        step_beats.insert(step_beats.size(), beat);
    endfunction

    function automatic void emit_replacement();
        emit_byte(utf8s_pkg::REP_BYTE0);
        emit_byte(utf8s_pkg::REP_BYTE1);
        emit_byte(utf8s_pkg::REP_BYTE2);
    endfunction

    function automatic void drop_pending();
        seq_len = utf8s_pkg::LEN_NONE;
        seq_cnt = 3'd0;
    endfunction

    function automatic void start_fresh(input logic [7:0] b);
        logic [2:0] n;
        n = seq_length_of(b);
        if (b < utf8s_pkg::CONT_MIN) begin
            emit_byte(b);
        end else if (n == utf8s_pkg::LEN_NONE) begin
            emit_replacement();
        end else begin
            seq_bytes[0] = b;
            seq_cnt      = 3'd1;
            seq_len      = n;
        end
    endfunction

    function automatic void predict_sanitized(input logic [7:0] b, input logic fin);
        step_beats.delete();
        if (seq_len != utf8s_pkg::LEN_NONE && seq_cnt >= 3'd1 && seq_cnt <= 3'd3) begin
            if (follows_lead(seq_bytes[0], seq_cnt, b)) begin
                if (int'(seq_cnt) + 1 >= int'(seq_len)) begin
                    for (int i = 0; i < int'(seq_cnt); i++) emit_byte(seq_bytes[i]);
                    emit_byte(b);
                    drop_pending();
                end else begin
                    seq_bytes[seq_cnt[1:0]] = b;
                    seq_cnt = seq_cnt + 3'd1;
                end
            end else begin
                emit_replacement();
                drop_pending();
                start_fresh(b);
            end
        end else begin
            drop_pending();
            start_fresh(b);
        end
        if (fin) begin
            if (seq_len != utf8s_pkg::LEN_NONE) emit_replacement();
            drop_pending();
        end
        if (step_beats.size() > 0) begin
            step_beats[step_beats.size() - 1].run_end    = 1'b1;
            step_beats[step_beats.size() - 1].stream_end = fin;
        end
        foreach (step_beats[i]) sanitized_q.insert(sanitized_q.size(), step_beats[i]);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (!steady && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_sanitized(b, fin);
        bytes_sent++;
    endtask

    task automatic send_rare_final(input logic [7:0] b);
        send_byte(b, $urandom_range(0, 19) == 0);
    endtask

    task automatic test_ascii_and_stray();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hC1, 1'b0);
        send_byte(8'hF5, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_complete_sequences();
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
    endtask

    task automatic test_second_byte_limits();
        send_byte(8'hE0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h90, 1'b0);
    endtask

    task automatic test_truncation_at_end();
        send_byte(8'hE1, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic build_sequence(output logic [7:0] seq[4], output int len);
        logic [7:0] lo;
        logic [7:0] hi;
        len = $urandom_range(2, 4);
        case (len)
            2: begin
                seq[0] = 8'($urandom_range(utf8s_pkg::LEAD2_MIN, utf8s_pkg::LEAD2_MAX));
            end
            3: begin
                seq[0] = 8'($urandom_range(utf8s_pkg::LEAD3_MIN, utf8s_pkg::LEAD3_MAX));
            end
            default: begin
                seq[0] = 8'($urandom_range(utf8s_pkg::LEAD4_MIN, utf8s_pkg::LEAD4_MAX));
            end
        endcase
        lo = utf8s_pkg::CONT_MIN;
        hi = utf8s_pkg::CONT_MAX;
        if (seq[0] == utf8s_pkg::LEAD_E0) lo = utf8s_pkg::LIMIT_A0;
        if (seq[0] == utf8s_pkg::LEAD_ED) hi = utf8s_pkg::LIMIT_A0 - 8'd1;
        if (seq[0] == utf8s_pkg::LEAD_F0) lo = utf8s_pkg::LIMIT_90;
        if (seq[0] == utf8s_pkg::LEAD_F4) hi = utf8s_pkg::LIMIT_90 - 8'd1;
        seq[1] = 8'($urandom_range(lo, hi));
        for (int i = 2; i < 4; i++) begin
            seq[i] = 8'($urandom_range(utf8s_pkg::CONT_MIN, utf8s_pkg::CONT_MAX));
        end
    endtask

    task automatic run_random_traffic(input int target);
        logic [7:0] seq[4];
        logic [7:0] bad;
        int         len;
        int         cut;
        int         pick;
        while (bytes_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_rare_final(8'($urandom_range(0, 127)));
            end else if (pick < 65) begin
                build_sequence(seq, len);
                for (int i = 0; i < len; i++) send_rare_final(seq[i]);
            end else if (pick < 82) begin
                build_sequence(seq, len);
                cut = $urandom_range(1, len - 1);
                for (int i = 0; i < cut; i++) send_rare_final(seq[i]);
                if ($urandom_range(0, 1) == 0) begin
                    bad = 8'($urandom_range(0, 127));
                end else begin
                    bad = 8'($urandom_range(8'hC0, 8'hFF));
                end
                if (cut == 1 && $urandom_range(0, 1) == 0) begin
                    case (seq[0])
                        utf8s_pkg::LEAD_E0: bad = 8'($urandom_range(8'h80, 8'h9F));
                        utf8s_pkg::LEAD_ED: bad = 8'($urandom_range(8'hA0, 8'hBF));
                        utf8s_pkg::LEAD_F0: bad = 8'($urandom_range(8'h80, 8'h8F));
                        utf8s_pkg::LEAD_F4: bad = 8'($urandom_range(8'h90, 8'hBF));
                        default: ;
                    endcase
                end
                send_rare_final(bad);
            end else begin
                send_rare_final(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_mixed_traffic(input int target);
        run_random_traffic(target);
    endtask

    task automatic test_back_to_back_traffic(input int target);
        steady = 1'b1;
        run_random_traffic(target);
        steady = 1'b0;
    endtask

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 25);
    end

    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (sanitized_q.size() == 0) begin
                $error("out_byte: unexpected transfer, actual %02h", m_tdata);
                mismatches++;
            end else begin
                want = sanitized_q.pop_front();
                if (m_tdata !== want.data) begin
                    $error("out_byte: expected %02h, actual %02h", want.data, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== want.run_end) begin
                    $error("run_end: expected %0d, actual %0d", want.run_end, m_tlast);
                    mismatches++;
                end
                if (m_tuser !== want.stream_end) begin
                    $error("stream_end: expected %0d, actual %0d", want.stream_end, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_ascii_and_stray();
        test_complete_sequences();
        test_second_byte_limits();
        test_truncation_at_end();
        test_mixed_traffic(200);
        test_back_to_back_traffic(330);
        test_mixed_traffic(460);
        s_tvalid <= 1'b0;
        while (sanitized_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/utf8s_pkg.sv
rtl/utf8s_front.sv
rtl/utf8s_queue.sv
rtl/utf8s_back.sv
rtl/utf8_sanitize_replace_core.sv
bench/tb_utf8_sanitize_replace_core.sv
